// File: hw/rtl/prs80_pkg.sv
// shared types, constants and round functions for the present-80 cipher
package prs80_pkg;

   localparam int unsigned ROUNDS = 31;
   localparam int unsigned RC_WIDTH = 5;
   localparam int unsigned KEY_WIDTH = 80;
   localparam int unsigned BLOCK_WIDTH = 64;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic CSR_KEY_LOW = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   localparam logic [3:0] SBOX_FWD [16] = '{
      4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
      4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };
   localparam logic [3:0] SBOX_INV [16] = '{
      4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
      4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
   };

   typedef struct packed {
      logic [63:0] block_in;
      logic        opcode;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] block_out;
      logic [63:0] final_key_low;
      logic [15:0] final_key_high;
   } rsp_payload_type;

   typedef struct packed {
      logic                   op;
      logic [BLOCK_WIDTH-1:0] block;
      logic [KEY_WIDTH-1:0]   key;
   } stage_type;

   function automatic logic [63:0] round_key(input logic [79:0] k);
      return k[79:16];
   endfunction

   function automatic logic [63:0] sbox_layer(input logic [63:0] x);
      logic [63:0] r;
      r = '0;
      for (int n = 0; n < 16; n++) begin
         r[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
      end
      return r;
   endfunction

   function automatic logic [63:0] inv_sbox_layer(input logic [63:0] x);
      logic [63:0] r;
      r = '0;
      for (int n = 0; n < 16; n++) begin
         r[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
      end
      return r;
   endfunction

   // bit i moves to 16*i mod 63, bit 63 stays
   function automatic logic [63:0] perm_layer(input logic [63:0] x);
      logic [63:0] r;
      logic [5:0]  idx;
      r = '0;
      for (int i = 0; i < 64; i++) begin
         idx = 6'(i);
         r[{idx[1:0], idx[5:2]}] = x[i];
      end
      return r;
   endfunction

   function automatic logic [63:0] inv_perm_layer(input logic [63:0] x);
      logic [63:0] r;
      logic [5:0]  idx;
      r = '0;
      for (int i = 0; i < 64; i++) begin
         idx = 6'(i);
         r[i] = x[{idx[1:0], idx[5:2]}];
      end
      return r;
   endfunction

   function automatic logic [79:0] key_advance(input logic [79:0] k,
                                               input logic [RC_WIDTH-1:0] rc);
      logic [79:0] t;
      t = {k[18:0], k[79:19]};
      t[79:76] = SBOX_FWD[t[79:76]];
      t[19:15] = t[19:15] ^ rc;
      return t;
   endfunction

   function automatic logic [79:0] key_retreat(input logic [79:0] k,
                                               input logic [RC_WIDTH-1:0] rc);
      logic [79:0] t;
      t = k;
      t[19:15] = t[19:15] ^ rc;
      t[79:76] = SBOX_INV[t[79:76]];
      return {t[60:0], t[79:61]};
   endfunction

endpackage

// File: hw/rtl/prs80_enc_cell.sv
// forward cell: one encryption round, or a key step only for decryption
module prs80_enc_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [prs80_pkg::RC_WIDTH-1:0]    round_count,
   input  logic                              up_valid,
   input  prs80_pkg::stage_type              up_stage,
   output logic                              cell_valid,
   output prs80_pkg::stage_type              cell_stage
);

   logic                 valid_ff;
   logic                 valid_in;
   prs80_pkg::stage_type stage_ff;
   prs80_pkg::stage_type stage_in;

   always_comb begin
      valid_in = up_valid;
      stage_in = up_stage;
      stage_in.key = prs80_pkg::key_advance(up_stage.key, round_count);
      if (up_stage.op == prs80_pkg::OP_ENCRYPT) begin
         stage_in.block = prs80_pkg::perm_layer(prs80_pkg::sbox_layer(
            up_stage.block ^ prs80_pkg::round_key(up_stage.key)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_stage = stage_ff;

endmodule

// File: hw/rtl/prs80_dec_cell.sv
// inverse cell: one decryption round, pass-through for encryption
module prs80_dec_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [prs80_pkg::RC_WIDTH-1:0]    round_count,
   input  logic                              up_valid,
   input  prs80_pkg::stage_type              up_stage,
   output logic                              cell_valid,
   output prs80_pkg::stage_type              cell_stage
);

   logic                 valid_ff;
   logic                 valid_in;
   prs80_pkg::stage_type stage_ff;
   prs80_pkg::stage_type stage_in;

   always_comb begin
      valid_in = up_valid;
      stage_in = up_stage;
      if (up_stage.op == prs80_pkg::OP_DECRYPT) begin
         stage_in.block = prs80_pkg::inv_sbox_layer(prs80_pkg::inv_perm_layer(
            up_stage.block ^ prs80_pkg::round_key(up_stage.key)));
         stage_in.key = prs80_pkg::key_retreat(up_stage.key, round_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_valid = valid_ff;
   assign cell_stage = stage_ff;

endmodule

// File: hw/rtl/present80_block_cipher.sv
// present-80 block cipher top level: key registers, cell chain, output register
// path from request transaction to rsp_valid: 31 forward cells,
//   31 inverse cells, one output register; throughput: one transaction per cycle while not stalled
// the whole chain advances together and holds while a response waits unaccepted
// reset clears all valid bits and both key registers to zero
module present80_block_cipher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  prs80_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output prs80_pkg::rsp_payload_type  rsp_payload,
   input  logic                        csr_we,
   input  logic                        csr_addr,
   input  logic [63:0]                 csr_wdata
);

   localparam int unsigned NUM_CELLS = 2 * prs80_pkg::ROUNDS;

   logic [63:0]                 key_low_ff;
   logic [63:0]                 key_low_in;
   logic [15:0]                 key_high_ff;
   logic [15:0]                 key_high_in;
   logic                        advance;
   logic [NUM_CELLS:0]          chain_valid;
   prs80_pkg::stage_type        chain_stage [NUM_CELLS+1];
   logic                        rsp_valid_ff;
   prs80_pkg::rsp_payload_type  rsp_payload_ff;
   prs80_pkg::rsp_payload_type  rsp_payload_in;

   always_comb begin
      key_low_in = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_we) begin
         case (csr_addr)
            prs80_pkg::CSR_KEY_LOW:  key_low_in = csr_wdata;
            prs80_pkg::CSR_KEY_HIGH: key_high_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= '0;
         key_high_ff <= '0;
      end else begin
         key_low_ff <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign chain_valid[0] = req_valid;
   assign chain_stage[0] = '{op: req_payload.opcode, block: req_payload.block_in,
                             key: {key_high_ff, key_low_ff}};

   for (genvar g = 0; g < prs80_pkg::ROUNDS; g++) begin : g_enc
      prs80_enc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .round_count (prs80_pkg::RC_WIDTH'(g + 1)),
         .up_valid    (chain_valid[g]),
         .up_stage    (chain_stage[g]),
         .cell_valid  (chain_valid[g+1]),
         .cell_stage  (chain_stage[g+1])
      );
   end

   for (genvar g = 0; g < prs80_pkg::ROUNDS; g++) begin : g_dec
      prs80_dec_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .round_count (prs80_pkg::RC_WIDTH'(prs80_pkg::ROUNDS - g)),
         .up_valid    (chain_valid[prs80_pkg::ROUNDS+g]),
         .up_stage    (chain_stage[prs80_pkg::ROUNDS+g]),
         .cell_valid  (chain_valid[prs80_pkg::ROUNDS+g+1]),
         .cell_stage  (chain_stage[prs80_pkg::ROUNDS+g+1])
      );
   end

   // final whitening with the current round key
   always_comb begin
      rsp_payload_in.block_out = chain_stage[NUM_CELLS].block ^
                                 prs80_pkg::round_key(chain_stage[NUM_CELLS].key);
      rsp_payload_in.final_key_low = chain_stage[NUM_CELLS].key[63:0];
      rsp_payload_in.final_key_high = chain_stage[NUM_CELLS].key[79:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_valid[NUM_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain_valid[NUM_CELLS:1]))
      else $error("cell chain moved during a stall");

   a_rsp_from_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(chain_valid[NUM_CELLS]))
      else $error("response appeared without a finished transaction");

   a_key_high_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_addr == prs80_pkg::CSR_KEY_HIGH |=> key_high_ff == $past(csr_wdata[15:0]))
      else $error("key_high write lost");

   a_key_low_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_addr == prs80_pkg::CSR_KEY_LOW |=> key_low_ff == $past(csr_wdata))
      else $error("key_low write lost");

endmodule

// File: sim/present80_block_cipher_test.sv
// self-checking testbench for the present-80 block cipher with key writes and random traffic
`timescale 1ns / 1ps

module present80_block_cipher_test;

   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES = 70;
   localparam int unsigned CHUNKS = 8;
   localparam int unsigned CHUNK_ITEMS = 225;

   class cipher_scoreboard;
      prs80_pkg::rsp_payload_type expected_q[$];
      logic [63:0]                key_low;
      logic [15:0]                key_high;
      int                         errors;

      function new();
         key_low = '0;
         key_high = '0;
         errors = 0;
      endfunction

      function void write_key(input logic idx, input logic [63:0] value);
         if (idx == prs80_pkg::CSR_KEY_LOW) begin
            key_low = value;
         end else begin
            key_high = value[15:0];
         end
      endfunction

      function logic [63:0] sub_nibbles(input logic [63:0] x, input bit inverse);
         logic [63:0] r;
         r = '0;
         for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = inverse ? prs80_pkg::SBOX_INV[x[4*n +: 4]]
                                  : prs80_pkg::SBOX_FWD[x[4*n +: 4]];
         end
         return r;
      endfunction

      function logic [63:0] scatter_bits(input logic [63:0] x, input bit inverse);
         logic [63:0] r;
         int          dest;
         r = '0;
         for (int i = 0; i < 64; i++) begin
            dest = (i == 63) ? 63 : (16 * i) % 63;
            if (inverse) begin
               r[i] = x[dest];
            end else begin
               r[dest] = x[i];
            end
         end
         return r;
      endfunction

      function logic [79:0] step_key(input logic [79:0] k, input logic [4:0] rc);
         logic [79:0] t;
         t = (k << 61) | (k >> 19);
         t[79:76] = prs80_pkg::SBOX_FWD[t[79:76]];
         t[19:15] = t[19:15] ^ rc;
         return t;
      endfunction

      function logic [79:0] unstep_key(input logic [79:0] k, input logic [4:0] rc);
         logic [79:0] t;
         t = k;
         t[19:15] = t[19:15] ^ rc;
         t[79:76] = prs80_pkg::SBOX_INV[t[79:76]];
         return (t << 19) | (t >> 61);
      endfunction

      function void note_request(input prs80_pkg::req_payload_type req);
         logic [63:0]                s;
         logic [79:0]                k;
         prs80_pkg::rsp_payload_type exp_rsp;
         s = req.block_in;
         k = {key_high, key_low};
         if (req.opcode == prs80_pkg::OP_ENCRYPT) begin
            for (int r = 1; r <= prs80_pkg::ROUNDS; r++) begin
               s = s ^ k[79:16];
               s = scatter_bits(sub_nibbles(s, 1'b0), 1'b0);
               k = step_key(k, 5'(r));
            end
         end else begin
            for (int r = 1; r <= prs80_pkg::ROUNDS; r++) begin
               k = step_key(k, 5'(r));
            end
            for (int r = prs80_pkg::ROUNDS; r >= 1; r--) begin
               s = s ^ k[79:16];
               s = sub_nibbles(scatter_bits(s, 1'b1), 1'b1);
               k = unstep_key(k, 5'(r));
            end
         end
         s = s ^ k[79:16];
         exp_rsp.block_out = s;
         exp_rsp.final_key_low = k[63:0];
         exp_rsp.final_key_high = k[79:64];
         expected_q.push_back(exp_rsp);
      endfunction

      function void check_response(input prs80_pkg::rsp_payload_type rsp);
         prs80_pkg::rsp_payload_type exp_rsp;
         if (expected_q.size() == 0) begin
            $error("unexpected response transaction: block_out %h", rsp.block_out);
            errors++;
         end else begin
            exp_rsp = expected_q.pop_front();
            if (rsp.block_out !== exp_rsp.block_out) begin
               $error("block_out mismatch: expected %h actual %h",
                      exp_rsp.block_out, rsp.block_out);
               errors++;
            end
            if (rsp.final_key_low !== exp_rsp.final_key_low) begin
               $error("final_key_low mismatch: expected %h actual %h",
                      exp_rsp.final_key_low, rsp.final_key_low);
               errors++;
            end
            if (rsp.final_key_high !== exp_rsp.final_key_high) begin
               $error("final_key_high mismatch: expected %h actual %h",
                      exp_rsp.final_key_high, rsp.final_key_high);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   prs80_pkg::req_payload_type req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   prs80_pkg::rsp_payload_type rsp_payload;
   logic                       csr_we = 1'b0;
   logic                       csr_addr = prs80_pkg::CSR_KEY_LOW;
   logic [63:0]                csr_wdata = '0;

   cipher_scoreboard sb = new();
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int unsigned      quiet_cycles = 0;

   present80_block_cipher u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_request(input prs80_pkg::req_payload_type item);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sb.note_request(item);
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   // key_high takes the full write word, upper bits must be dropped
   task automatic set_cipher_key(input logic [63:0] lo, input logic [63:0] hi_word);
      csr_we <= 1'b1;
      csr_addr <= prs80_pkg::CSR_KEY_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      sb.write_key(prs80_pkg::CSR_KEY_LOW, lo);
      csr_addr <= prs80_pkg::CSR_KEY_HIGH;
      csr_wdata <= hi_word;
      @(posedge clock);
      sb.write_key(prs80_pkg::CSR_KEY_HIGH, hi_word);
      csr_we <= 1'b0;
   endtask

   task automatic run_corner_blocks();
      prs80_pkg::req_payload_type item;
      logic [63:0]     patterns[3] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_AAAA_0F0F_F0F0};
      for (int p = 0; p < 3; p++) begin
         for (int op = 0; op < 2; op++) begin
            item.block_in = patterns[p];
            item.opcode = (op == 0) ? prs80_pkg::OP_ENCRYPT : prs80_pkg::OP_DECRYPT;
            send_request(item);
         end
      end
   endtask

   function automatic logic [63:0] random_block();
      case ($urandom_range(15))
         0: return 64'h0;
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         2: return 64'h1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      prs80_pkg::req_payload_type item;
      int                         mode;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key, then extreme and mixed keys
      run_corner_blocks();
      wait_all_responses();
      set_cipher_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      run_corner_blocks();
      wait_all_responses();
      set_cipher_key(64'h0, 64'hFFFF_FFFF_FFFF_0000);
      run_corner_blocks();
      wait_all_responses();
      set_cipher_key(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      item.block_in = 64'h0123_4567_89AB_CDEF;
      item.opcode = prs80_pkg::OP_ENCRYPT;
      send_request(item);
      item.opcode = prs80_pkg::OP_DECRYPT;
      send_request(item);

      for (int c = 0; c < CHUNKS; c++) begin
         wait_all_responses();
         case (c % 4)
            0: set_cipher_key({$urandom, $urandom}, {$urandom, $urandom});
            1: set_cipher_key(64'h0, 64'h0);
            2: set_cipher_key(64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom});
            default: set_cipher_key({$urandom, $urandom}, 64'hFFFF);
         endcase
         mode = (c + c / 4) % 4;
         send_idle_pct = (mode == 1) ? 85 : (mode == 3) ? 8 : 0;
         recv_stall_pct = (mode == 2) ? 85 : (mode == 3) ? 8 : 0;
         for (int n = 0; n < CHUNK_ITEMS; n++) begin
            if (c % 2 == 1 && n == CHUNK_ITEMS / 2) begin
               wait_all_responses();
            end
            item.block_in = random_block();
            item.opcode = $urandom_range(1) ? prs80_pkg::OP_DECRYPT : prs80_pkg::OP_ENCRYPT;
            send_request(item);
         end
      end

      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
